FILE: hw/rtl/modbus_rtu_meter_response_parser_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the meter response parser
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_METER_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_METER_RESPONSE_PARSER_ASSERT_SVH

// same-cycle implication
`define MRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("meter response parser check failed");

// next-cycle implication
`define MRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("meter response parser check failed");

`endif

FILE: hw/rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// types, constants and the crc-16 byte update of the meter response parser
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int unsigned IdxW = 5;

  localparam logic [IdxW-1:0] IdxLast = 5'd24;
  localparam logic [IdxW-1:0] CrcSpan = 5'd23;
  localparam logic [IdxW-1:0] IdxAddr = 5'd0;
  localparam logic [IdxW-1:0] IdxFunc = 5'd1;
  localparam logic [IdxW-1:0] IdxCount = 5'd2;
  localparam logic [IdxW-1:0] IdxCrcLow = 5'd23;

  localparam logic [7:0]  FuncCode = 8'h04;
  localparam logic [7:0]  DataCount = 8'd20;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  SlaveAddrReset = 8'd248;

  localparam int unsigned PaddrW = 2;
  localparam logic [PaddrW-3+1:0] RegSlaveAddr = 1'b0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_BAD_ADDR   = 3'd2,
    ST_BAD_FUNC   = 3'd3,
    ST_BAD_COUNT  = 3'd4,
    ST_BAD_CRC    = 3'd5
  } status_e;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/modbus_rtu_meter_response_parser.sv
// ----------------------------------------------------------------------------
// modbus_rtu_meter_response_parser
// parses a 25-byte read-input-registers reply into status and meter readings
// ----------------------------------------------------------------------------
// Takes one word per cycle: a received byte or a receive timeout tick. The
// crc-16 byte update, the header checks and the field captures all finish in
// the cycle the word is accepted, so the rate is one word per clock unstalled.
// Results sit in an output register; the input stalls only when the word
// would complete a frame (last byte or timeout) while a result is still
// held and stalled downstream. Voltage comes in 0.1 V, current in mA and
// power in 0.1 W; readings are zero whenever status is not ok.
// ----------------------------------------------------------------------------
`include "modbus_rtu_meter_response_parser_assert.svh"

module modbus_rtu_meter_response_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] voltage_tenths_o,
  output logic [31:0] current_milliamps_o,
  output logic [31:0] power_tenths_o
);
  import mbrtu_pkg::*;

  logic [7:0]      slave_addr_q;
  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [15:0]     crc_q, crc_d;
  status_e         first_err_q, first_err_d;
  logic [7:0]      crc_low_q, crc_low_d;
  logic [15:0]     volt_q, volt_d;
  logic [31:0]     curr_q, curr_d;
  logic [31:0]     pwr_q, pwr_d;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [15:0]     volt_out_q, volt_out_d;
  logic [31:0]     curr_out_q, curr_out_d;
  logic [31:0]     pwr_out_q, pwr_out_d;

  logic            in_accept;
  logic            will_emit;
  logic            out_free;
  logic [15:0]     got_crc;
  status_e         final_err;

  // config port
  assign pready = 1'b1;
  assign prdata = {24'h000000, slave_addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr == PaddrW'(4 * RegSlaveAddr)) begin
      slave_addr_q <= pwdata[7:0];
    end
  end

  // handshake
  assign will_emit  = mode_i || (byte_index_q >= IdxLast);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = will_emit && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign got_crc = {rx_byte_i, crc_low_q};

  always_comb begin
    if (first_err_q != ST_OK) begin
      final_err = first_err_q;
    end else if (got_crc != crc_q) begin
      final_err = ST_BAD_CRC;
    end else begin
      final_err = ST_OK;
    end
  end

  // frame state
  always_comb begin
    byte_index_d = byte_index_q;
    crc_d        = crc_q;
    first_err_d  = first_err_q;
    crc_low_d    = crc_low_q;
    volt_d       = volt_q;
    curr_d       = curr_q;
    pwr_d        = pwr_q;
    if (in_accept) begin
      if (will_emit) begin
        byte_index_d = '0;
        crc_d        = CrcInit;
        first_err_d  = ST_OK;
        crc_low_d    = '0;
        volt_d       = '0;
        curr_d       = '0;
        pwr_d        = '0;
      end else begin
        byte_index_d = byte_index_q + 1'b1;
        if (byte_index_q < CrcSpan) begin
          crc_d = crc16_update(crc_q, rx_byte_i);
        end
        if (first_err_q == ST_OK) begin
          if (byte_index_q == IdxAddr && rx_byte_i != slave_addr_q) begin
            first_err_d = ST_BAD_ADDR;
          end else if (byte_index_q == IdxFunc && rx_byte_i != FuncCode) begin
            first_err_d = ST_BAD_FUNC;
          end else if (byte_index_q == IdxCount && rx_byte_i != DataCount) begin
            first_err_d = ST_BAD_COUNT;
          end
        end
        unique case (byte_index_q)
          5'd3:      volt_d[15:8]  = rx_byte_i;
          5'd4:      volt_d[7:0]   = rx_byte_i;
          5'd5:      curr_d[15:8]  = rx_byte_i;
          5'd6:      curr_d[7:0]   = rx_byte_i;
          5'd7:      curr_d[31:24] = rx_byte_i;
          5'd8:      curr_d[23:16] = rx_byte_i;
          5'd9:      pwr_d[15:8]   = rx_byte_i;
          5'd10:     pwr_d[7:0]    = rx_byte_i;
          5'd11:     pwr_d[31:24]  = rx_byte_i;
          5'd12:     pwr_d[23:16]  = rx_byte_i;
          IdxCrcLow: crc_low_d     = rx_byte_i;
          default:   ;
        endcase
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    volt_out_d  = volt_out_q;
    curr_out_d  = curr_out_q;
    pwr_out_d   = pwr_out_q;
    if (in_accept && will_emit) begin
      out_valid_d = 1'b1;
      if (mode_i) begin
        status_d   = ST_INCOMPLETE;
        volt_out_d = '0;
        curr_out_d = '0;
        pwr_out_d  = '0;
      end else begin
        status_d = final_err;
        if (final_err == ST_OK) begin
          volt_out_d = volt_q;
          curr_out_d = curr_q;
          pwr_out_d  = pwr_q;
        end else begin
          volt_out_d = '0;
          curr_out_d = '0;
          pwr_out_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      crc_q        <= CrcInit;
      first_err_q  <= ST_OK;
      crc_low_q    <= '0;
      volt_q       <= '0;
      curr_q       <= '0;
      pwr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      crc_q        <= crc_d;
      first_err_q  <= first_err_d;
      crc_low_q    <= crc_low_d;
      volt_q       <= volt_d;
      curr_q       <= curr_d;
      pwr_q        <= pwr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    volt_out_q <= volt_out_d;
    curr_out_q <= curr_out_d;
    pwr_out_q  <= pwr_out_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign voltage_tenths_o    = volt_out_q;
  assign current_milliamps_o = curr_out_q;
  assign power_tenths_o      = pwr_out_q;

  `MRP_ASSERT_NOW(a_index_range, clk_i, rst_ni, 1'b1, byte_index_q <= IdxLast)
  `MRP_ASSERT_NEXT(a_timeout_result, clk_i, rst_ni, in_accept && mode_i,
                   out_valid_q && status_q == ST_INCOMPLETE)
  `MRP_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, in_accept && will_emit,
                   byte_index_q == '0 && crc_q == CrcInit && first_err_q == ST_OK)
  `MRP_ASSERT_NOW(a_error_zero_data, clk_i, rst_ni, out_valid_q && status_q != ST_OK,
                  volt_out_q == '0 && curr_out_q == '0 && pwr_out_q == '0)

endmodule

FILE: tb/meter_reply_checker.sv
// ----------------------------------------------------------------------------
// meter_reply_checker
// watches the byte and reply channels of the meter response parser, predicts
// every reply from the accepted words and compares it field by field
// ----------------------------------------------------------------------------
module meter_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  status_o,
  input  logic [15:0] voltage_tenths_o,
  input  logic [31:0] current_milliamps_o,
  input  logic [31:0] power_tenths_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import mbrtu_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] volt;
    logic [31:0] cur;
    logic [31:0] pwr;
  } reading_t;

  logic [7:0]  addr_cfg;
  logic [4:0]  byte_pos;
  logic [15:0] crc_acc;
  status_e     frame_err;
  logic [7:0]  crc_lo;
  logic [15:0] volt_cap;
  logic [31:0] cur_cap;
  logic [31:0] pwr_cap;
  reading_t    reading_q[$];
  int unsigned fails;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  task automatic clear_frame();
    byte_pos = '0;
    crc_acc = CrcInit;
    frame_err = ST_OK;
    crc_lo = '0;
    volt_cap = '0;
    cur_cap = '0;
    pwr_cap = '0;
  endtask

  task automatic note_error(input status_e code);
    if (frame_err == ST_OK) begin
      frame_err = code;
    end
  endtask

  task automatic predict_reading(input logic m, input logic [7:0] b);
    reading_t    r;
    logic [15:0] got;
    r = '0;
    if (m) begin
      r.status = ST_INCOMPLETE;
      reading_q.push_back(r);
      clear_frame();
    end else begin
      if (byte_pos < CrcSpan) begin
        crc_acc = crc_byte(crc_acc, b);
      end
      case (byte_pos)
        IdxAddr: if (b != addr_cfg) note_error(ST_BAD_ADDR);
        IdxFunc: if (b != FuncCode) note_error(ST_BAD_FUNC);
        IdxCount: if (b != DataCount) note_error(ST_BAD_COUNT);
        5'd3: volt_cap[15:8] = b;
        5'd4: volt_cap[7:0] = b;
        5'd5: cur_cap[15:8] = b;
        5'd6: cur_cap[7:0] = b;
        5'd7: cur_cap[31:24] = b;
        5'd8: cur_cap[23:16] = b;
        5'd9: pwr_cap[15:8] = b;
        5'd10: pwr_cap[7:0] = b;
        5'd11: pwr_cap[31:24] = b;
        5'd12: pwr_cap[23:16] = b;
        IdxCrcLow: crc_lo = b;
        default: ;
      endcase
      if (byte_pos >= IdxLast) begin
        got = {b, crc_lo};
        if (got != crc_acc) begin
          note_error(ST_BAD_CRC);
        end
        r.status = frame_err;
        if (frame_err == ST_OK) begin
          r.volt = volt_cap;
          r.cur = cur_cap;
          r.pwr = pwr_cap;
        end
        reading_q.push_back(r);
        clear_frame();
      end else begin
        byte_pos = byte_pos + 5'd1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    reading_t r;
    if (!rst_ni) begin
      addr_cfg = SlaveAddrReset;
      clear_frame();
      reading_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == PaddrW'(4 * RegSlaveAddr)) begin
        addr_cfg = pwdata[7:0];
      end
      if (in_valid_i && !in_stall_o) begin
        predict_reading(mode_i, rx_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (reading_q.size() == 0) begin
          $error("unexpected reply word, status %0d", status_o);
          fails++;
        end else begin
          r = reading_q.pop_front();
          if (status_o !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status_o);
            fails++;
          end
          if (voltage_tenths_o !== r.volt) begin
            $error("voltage_tenths: expected %0h, actual %0h", r.volt, voltage_tenths_o);
            fails++;
          end
          if (current_milliamps_o !== r.cur) begin
            $error("current_milliamps: expected %0h, actual %0h", r.cur, current_milliamps_o);
            fails++;
          end
          if (power_tenths_o !== r.pwr) begin
            $error("power_tenths: expected %0h, actual %0h", r.pwr, power_tenths_o);
            fails++;
          end
        end
      end
    end
    fail_count_o = fails;
    pending_o = reading_q.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the meter response parser: well-formed replies with random
// readings, header and crc errors, truncated frames, timeouts and noise,
// under several responder addresses and random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import mbrtu_pkg::*;

  typedef enum int {
    FrGood,
    FrBadAddr,
    FrBadFunc,
    FrBadCount,
    FrBadCrc,
    FrMulti
  } frame_kind_e;

  typedef enum int {
    FillRandom,
    FillZeros,
    FillOnes
  } fill_e;

  localparam int unsigned FrameLen = 25;
  localparam int unsigned HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [15:0] voltage_tenths_o;
  logic [31:0] current_milliamps_o;
  logic [31:0] power_tenths_o;
  int unsigned fail_count;
  int unsigned pending;

  bit          quiet;
  bit          hold_go;
  int unsigned words_sent;
  logic [7:0]  addr_now;
  logic [7:0]  frame_b [FrameLen];

  modbus_rtu_meter_response_parser u_top (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .voltage_tenths_o,
    .current_milliamps_o,
    .power_tenths_o
  );

  meter_reply_checker u_check (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .voltage_tenths_o,
    .current_milliamps_o,
    .power_tenths_o,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_go = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [15:0] frame_crc();
    logic [15:0] c;
    c = CrcInit;
    for (int i = 0; i < CrcSpan; i++) begin
      c = c ^ {8'h00, frame_b[i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
    end
    return c;
  endfunction

  task automatic make_frame(input frame_kind_e kind, input fill_e fill);
    logic [15:0] crc;
    frame_b[0] = addr_now;
    frame_b[1] = FuncCode;
    frame_b[2] = DataCount;
    for (int i = 3; i < CrcSpan; i++) begin
      case (fill)
        FillZeros: frame_b[i] = 8'h00;
        FillOnes: frame_b[i] = 8'hFF;
        default: frame_b[i] = 8'($urandom_range(0, 255));
      endcase
    end
    if (kind == FrBadAddr || (kind == FrMulti && $urandom_range(0, 1) == 1)) begin
      frame_b[0] = frame_b[0] ^ 8'($urandom_range(1, 255));
    end
    if (kind == FrBadFunc || (kind == FrMulti && $urandom_range(0, 1) == 1)) begin
      frame_b[1] = frame_b[1] ^ 8'($urandom_range(1, 255));
    end
    if (kind == FrBadCount || (kind == FrMulti && $urandom_range(0, 1) == 1)) begin
      frame_b[2] = frame_b[2] ^ 8'($urandom_range(1, 255));
    end
    crc = frame_crc();
    frame_b[23] = crc[7:0];
    frame_b[24] = crc[15:8];
    if (kind == FrBadCrc || (kind == FrMulti && $urandom_range(0, 1) == 1)) begin
      frame_b[23 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    end
  endtask

  task automatic send_word(input logic m, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_frame(input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_word(1'b0, frame_b[i]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_addr(input logic [7:0] a);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'(4 * RegSlaveAddr);
    pwdata <= {24'h0, a};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    addr_now = a;
    @(posedge clk_i);
  endtask

  task automatic run_until(input int unsigned goal);
    int unsigned pick;
    int unsigned n;
    fill_e       fill;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 99);
      n = $urandom_range(0, 9);
      fill = (n == 0) ? FillZeros : (n == 1) ? FillOnes : FillRandom;
      if (pick < 50) begin
        make_frame(FrGood, fill);
        send_frame(FrameLen);
      end else if (pick < 57) begin
        make_frame(FrBadAddr, fill);
        send_frame(FrameLen);
      end else if (pick < 63) begin
        make_frame(FrBadFunc, fill);
        send_frame(FrameLen);
      end else if (pick < 69) begin
        make_frame(FrBadCount, fill);
        send_frame(FrameLen);
      end else if (pick < 78) begin
        make_frame(FrBadCrc, fill);
        send_frame(FrameLen);
      end else if (pick < 84) begin
        make_frame(FrMulti, fill);
        send_frame(FrameLen);
      end else if (pick < 92) begin
        make_frame(FrGood, fill);
        send_frame($urandom_range(0, FrameLen - 1));
        send_word(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
          send_word($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) != 0) begin
          send_word(1'b1, 8'($urandom_range(0, 255)));
        end
      end else begin
        send_word(1'b1, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    mode_i <= 1'b0;
    rx_byte_i <= '0;
    quiet = 1'b0;
    hold_go = 1'b0;
    words_sent = 0;
    addr_now = SlaveAddrReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // timeout on an empty frame, then a clean reply with full-scale readings
    send_word(1'b1, 8'hA5);
    make_frame(FrGood, FillOnes);
    send_frame(FrameLen);
    drain();

    write_addr(8'h00);
    run_until(500);
    drain();

    write_addr(8'hFF);
    hold_go = 1'b1;
    run_until(900);
    drain();

    write_addr(8'($urandom_range(1, 254)));
    run_until(1300);
    drain();

    write_addr(SlaveAddrReset);
    run_until(1500);
    quiet = 1'b1;
    run_until(1800);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
